### rtl/core/cpg_pkg.sv
// Shared constants and control types of the circle point generator.
package cpg_pkg;

	// Default sizes of the quadrant store and the radius range.
	localparam int MAX_QUADRANT_POINTS_DEF = 1024;
	localparam int MAX_RADIUS_DEF = 511;

	// Fixed widths of the beat fields.
	localparam int CENTER_W = 12;
	localparam int RADIUS_W = 9;
	localparam int POINT_W = 13;

	// Codes of the mode field.
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_NEXT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start_load;
		logic walk_step;
		logic emit_read;
		logic out_load;
	} cpg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_last;
		logic out_blocked;
	} cpg_sts_t;

endpackage

### rtl/core/cpg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cpg_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds when not enabled.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/cpg_ctrl.sv
// Controller state machine of the circle point generator.
module cpg_ctrl import cpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  logic     mode,
	output logic     cmd_stall,
	input  cpg_sts_t sts,
	output cpg_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} cpg_state_t;

	cpg_state_t state_q, state_d;

	// New beats are taken only while idle.
	assign cmd_stall = (state_q != ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (mode == MODE_START) begin
						cmd.start_load = 1'b1;
						state_d = ST_WALK;
					end else begin
						cmd.emit_read = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!sts.out_blocked) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/cpg_datapath.sv
// Datapath: quadrant walk, quadrant store, emission addressing and result register.
module cpg_datapath import cpg_pkg::*; #(
	parameter int MAX_QUADRANT_POINTS = MAX_QUADRANT_POINTS_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cpg_cmd_t                   cmd,
	output cpg_sts_t                   sts,
	input  logic signed [CENTER_W-1:0] center_x,
	input  logic signed [CENTER_W-1:0] center_y,
	input  logic [RADIUS_W-1:0]        radius,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       point_valid,
	output logic signed [POINT_W-1:0]  point_x,
	output logic signed [POINT_W-1:0]  point_y,
	output logic                       last_point
);

	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int RCW = (RW > RADIUS_W) ? RW : RADIUS_W;
	localparam int NW = $clog2(MAX_QUADRANT_POINTS + 1);
	localparam int AW = $clog2(MAX_QUADRANT_POINTS);
	localparam int EW = NW + 2;
	localparam int CW = RW + 2;
	localparam int DW = RW + 4;
	localparam int PW = RW + 7;
	localparam int MW = 2 * RW;
	localparam int OW = (RW + 2 > POINT_W) ? RW + 2 : POINT_W;

	localparam logic signed [DW-1:0] D_TWO = DW'(2);
	localparam logic signed [DW-1:0] D_THREE = DW'(3);
	localparam logic signed [PW-1:0] P_THREE = PW'(3);

	// Walk state.
	logic signed [CW-1:0] x_q, y_q, x_next, y_next;
	logic signed [DW-1:0] d_q, d_next, d_init, r_d, x_d, y_d;
	logic signed [PW-1:0] p_h, p_v;
	logic [NW-1:0]        count_q, count_inc;
	logic [RCW-1:0]       r_wide;
	logic [RW-1:0]        r_sat;
	logic                 go_x, go_y;

	// Latched center and emission position.
	logic signed [CENTER_W-1:0] cx_q, cy_q;
	logic [EW-1:0]              emit_q;

	// Emission addressing.
	logic [EW-1:0] nn, n2, n4, total, pos, j, addr_e;
	logic          exhausted, negx_e, negy_e;

	// Read-stage flags and store data.
	logic          ev_s1, negx_s1, negy_s1, last_s1;
	logic [MW-1:0] rdata;

	// Result assembly.
	logic signed [OW-1:0] ox_s, oy_s, offx, offy, sum_x, sum_y;
	logic                 res_valid_q;

	// Radius saturation to the supported range.
	always_comb begin
		r_wide = RCW'(radius);
		if (r_wide > RCW'(MAX_RADIUS)) begin
			r_wide = RCW'(MAX_RADIUS);
		end
	end
	assign r_sat = r_wide[RW-1:0];
	assign r_d = signed'(DW'(r_sat));
	assign d_init = D_TWO - (r_d <<< 1);

	// Move choice from the sign of d and of the scaled midpoint test.
	assign x_d = DW'(x_q);
	assign y_d = DW'(y_q);
	assign p_h = (PW'(d_q) <<< 2) + (PW'(y_q) <<< 2) - P_THREE;
	assign p_v = (PW'(d_q) <<< 2) - (PW'(x_q) <<< 2) - P_THREE;

	always_comb begin
		if (d_q < 0) begin
			go_x = 1'b1;
			go_y = (p_h > 0);
		end else if (d_q > 0) begin
			go_x = (p_v <= 0);
			go_y = 1'b1;
		end else begin
			go_x = 1'b1;
			go_y = 1'b1;
		end
	end

	// Incremental update of d: a step in x adds 2x+3, a step down in y adds 3-2y.
	always_comb begin
		d_next = d_q;
		if (go_x) begin
			d_next = d_next + (x_d <<< 1) + D_THREE;
		end
		if (go_y) begin
			d_next = d_next - (y_d <<< 1) + D_THREE;
		end
	end
	assign x_next = go_x ? x_q + CW'(1) : x_q;
	assign y_next = go_y ? y_q - CW'(1) : y_q;
	assign count_inc = count_q + NW'(1);

	// The walk ends when y goes negative or the store is full.
	assign sts.walk_last = y_next[CW-1] || (count_inc == NW'(MAX_QUADRANT_POINTS));

	// Walk registers.
	always_ff @(posedge clk) begin
		if (cmd.start_load) begin
			x_q <= '0;
			y_q <= signed'(CW'(r_sat));
			d_q <= d_init;
		end else if (cmd.walk_step) begin
			x_q <= x_next;
			y_q <= y_next;
			d_q <= d_next;
		end
	end

	// Point count, center and emission position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			emit_q <= '0;
		end else begin
			if (cmd.start_load) begin
				count_q <= '0;
				cx_q <= center_x;
				cy_q <= center_y;
				emit_q <= '0;
			end else begin
				if (cmd.walk_step) begin
					count_q <= count_inc;
				end
				if (cmd.out_load && ev_s1) begin
					emit_q <= emit_q + EW'(1);
				end
			end
		end
	end

	// Map the circle position onto a store address and mirror signs.
	assign nn = EW'(count_q);
	assign n2 = nn << 1;
	assign n4 = nn << 2;
	assign total = (count_q == '0) ? '0 : n4 - EW'(4);
	assign exhausted = (emit_q >= total);
	assign pos = emit_q + EW'(1);
	assign j = n4 - EW'(2) - pos;

	always_comb begin
		negx_e = 1'b0;
		negy_e = 1'b0;
		if (pos <= nn) begin
			addr_e = pos - EW'(1);
		end else if (pos <= n2 - EW'(1)) begin
			addr_e = n2 - pos - EW'(1);
			negy_e = 1'b1;
		end else if (j <= nn) begin
			addr_e = j - EW'(1);
			negx_e = 1'b1;
		end else begin
			addr_e = pos + EW'(1) - n2;
			negx_e = 1'b1;
			negy_e = 1'b1;
		end
	end

	// Quadrant store: written by the walk, read at most once per next beat.
	cpg_ram #(
		.WIDTH (MW),
		.DEPTH (MAX_QUADRANT_POINTS)
	) u_store (
		.clk   (clk),
		.we    (cmd.walk_step),
		.waddr (count_q[AW-1:0]),
		.wdata ({x_q[RW-1:0], y_q[RW-1:0]}),
		.re    (cmd.emit_read && !exhausted),
		.raddr (addr_e[AW-1:0]),
		.rdata (rdata)
	);

	// Flags that travel alongside the store read.
	always_ff @(posedge clk) begin
		if (cmd.emit_read) begin
			ev_s1 <= !exhausted;
			negx_s1 <= negx_e;
			negy_s1 <= negy_e;
			last_s1 <= (pos == total);
		end
	end

	// Offset by the center, wrapping to the output width.
	assign ox_s = signed'(OW'(rdata[MW-1:RW]));
	assign oy_s = signed'(OW'(rdata[RW-1:0]));
	assign offx = negx_s1 ? -ox_s : ox_s;
	assign offy = negy_s1 ? -oy_s : oy_s;
	assign sum_x = OW'(cx_q) + offx;
	assign sum_y = OW'(cy_q) + offy;

	// A held result blocks the next one.
	assign sts.out_blocked = res_valid_q && res_stall;

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload; an exhausted sequence gives all zeros.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			point_valid <= ev_s1;
			point_x <= ev_s1 ? sum_x[POINT_W-1:0] : '0;
			point_y <= ev_s1 ? sum_y[POINT_W-1:0] : '0;
			last_point <= ev_s1 && last_s1;
		end
	end

	assign res_valid = res_valid_q;

endmodule

### rtl/core/circle_point_generator.sv
// Top level of the midpoint circle point generator.
//
// Command channel (cmd_valid, cmd_stall): a beat with mode start latches
// center_x, center_y and radius and walks the first quadrant, storing one
// point per cycle; it gives no result. Let n be the number of quadrant
// points (about 1.41 * radius + 1). cmd_stall is high during the walk.
// A beat with mode next gives exactly one result beat on the result channel
// (res_valid, res_stall): the next point of the clockwise circle, 4n-4 in
// all, with last_point on the final one. After the sequence ends, or before
// any start, the result has every field zero. A next beat reads the store
// first, then adds the center into the result register; no new command beat
// is taken until that load is done. The result register lets a new command
// beat be taken while a result is held; a stalled result holds, and the
// following next beat waits in its emit state until the result register
// frees.
// Reset (arst_n low) clears the point count, the center and the position;
// the store needs no clearing, as only points of the latest walk are read.
module circle_point_generator import cpg_pkg::*; #(
	parameter int MAX_QUADRANT_POINTS = MAX_QUADRANT_POINTS_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic                       mode,
	input  logic signed [CENTER_W-1:0] center_x,
	input  logic signed [CENTER_W-1:0] center_y,
	input  logic [RADIUS_W-1:0]        radius,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       point_valid,
	output logic signed [POINT_W-1:0]  point_x,
	output logic signed [POINT_W-1:0]  point_y,
	output logic                       last_point
);

	cpg_cmd_t cmd;
	cpg_sts_t sts;

	// Sequencing of walk and emission.
	cpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.mode      (mode),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic, store and result register.
	cpg_datapath #(
		.MAX_QUADRANT_POINTS (MAX_QUADRANT_POINTS),
		.MAX_RADIUS          (MAX_RADIUS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.point_valid (point_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_point  (last_point)
	);

	// A held result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(res_valid && res_stall))
		else $error("result register loaded while a result is stalled");

	// An accepted next beat keeps the command side busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && mode == MODE_NEXT) |=> cmd_stall)
		else $error("command taken while a point read is in flight");

	// An exhausted result carries only zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !point_valid) |-> (point_x == '0 && point_y == '0 && !last_point))
		else $error("exhausted result with nonzero fields");

	// The walk and the emission never run together.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.walk_step && (cmd.emit_read || cmd.out_load)))
		else $error("walk overlaps a point emission");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench: drives start and next beats, predicts circle points, checks results.
module tb_top import cpg_pkg::*;;

	// One command beat as queued for the driver.
	typedef struct {
		logic                       mode;
		logic signed [CENTER_W-1:0] cx;
		logic signed [CENTER_W-1:0] cy;
		logic [RADIUS_W-1:0]        rad;
		bit                         hold;
	} cmd_beat_t;

	// One result beat as it should appear on the result channel.
	typedef struct {
		logic                      pv;
		logic signed [POINT_W-1:0] px;
		logic signed [POINT_W-1:0] py;
		logic                      last;
	} point_beat_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cmd_valid = 1'b0;
	logic                       cmd_stall;
	logic                       mode = MODE_START;
	logic signed [CENTER_W-1:0] center_x = '0;
	logic signed [CENTER_W-1:0] center_y = '0;
	logic [RADIUS_W-1:0]        radius = '0;
	logic                       res_valid;
	logic                       res_stall = 1'b0;
	logic                       point_valid;
	logic signed [POINT_W-1:0]  point_x;
	logic signed [POINT_W-1:0]  point_y;
	logic                       last_point;

	cmd_beat_t   cmd_backlog[$];
	point_beat_t points_due[$];
	cmd_beat_t   on_bus;

	// Predicted state: the stored quadrant arc, the emit position and the center.
	int arc_x[MAX_QUADRANT_POINTS_DEF];
	int arc_y[MAX_QUADRANT_POINTS_DEF];
	int arc_len = 0;
	int emit_pos = 0;
	int ctr_x = 0;
	int ctr_y = 0;

	int fails = 0;
	int cmd_gap = 0;
	int cmd_calm = 0;
	int res_wait = 0;
	int res_calm = 0;

	circle_point_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.mode       (mode),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.point_valid(point_valid),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point)
	);

	// Clock and a single reset pulse at the start.
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Walks the first quadrant from (0,r) with the midpoint tests scaled by four.
	function automatic void trace_arc(input int r);
		int x;
		int y;
		int d;
		int p;
		if (r > MAX_RADIUS_DEF)
			r = MAX_RADIUS_DEF;
		x = 0;
		y = r;
		arc_len = 0;
		while (y >= 0 && arc_len < MAX_QUADRANT_POINTS_DEF) begin
			arc_x[arc_len] = x;
			arc_y[arc_len] = y;
			arc_len++;
			d = (x + 1) * (x + 1) + (y - 1) * (y - 1) - r * r;
			if (d < 0) begin
				// Horizontal unless the midpoint lies outside the circle.
				p = 4 * (x + 1) * (x + 1) + (2 * y - 1) * (2 * y - 1) - 4 * r * r;
				x++;
				if (p > 0)
					y--;
			end else if (d > 0) begin
				// Vertical unless the midpoint lies inside the circle.
				p = (2 * x + 1) * (2 * x + 1) + 4 * (y - 1) * (y - 1) - 4 * r * r;
				if (p <= 0)
					x++;
				y--;
			end else begin
				x++;
				y--;
			end
		end
	endfunction

	// Applies one accepted command beat and queues the point it should produce.
	function automatic void apply_cmd(input cmd_beat_t c);
		point_beat_t pt;
		int total;
		int pos;
		int k;
		int ox;
		int oy;
		if (c.mode == MODE_START) begin
			ctr_x = c.cx;
			ctr_y = c.cy;
			trace_arc(int'(c.rad));
			emit_pos = 0;
		end else begin
			pt.pv = 1'b0;
			pt.px = '0;
			pt.py = '0;
			pt.last = 1'b0;
			total = (arc_len == 0) ? 0 : 4 * arc_len - 4;
			if (emit_pos < total) begin
				pos = emit_pos + 1;
				if (pos <= arc_len) begin
					// First quadrant, in walk order.
					ox = arc_x[pos - 1];
					oy = arc_y[pos - 1];
				end else if (pos <= 2 * arc_len - 1) begin
					// Fourth quadrant, mirrored in y and walked backwards.
					k = 2 * arc_len - pos;
					ox = arc_x[k - 1];
					oy = -arc_y[k - 1];
				end else begin
					// Left half, the right half mirrored in x.
					k = 4 * arc_len - 2 - pos;
					if (k <= arc_len) begin
						ox = -arc_x[k - 1];
						oy = arc_y[k - 1];
					end else begin
						k = 2 * arc_len - k;
						ox = -arc_x[k - 1];
						oy = -arc_y[k - 1];
					end
				end
				pt.pv = 1'b1;
				pt.px = POINT_W'(ctr_x + ox);
				pt.py = POINT_W'(ctr_y + oy);
				pt.last = (pos == total);
				emit_pos++;
			end
			points_due.push_back(pt);
		end
	endfunction

	// Command driver: presents queued beats, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin : drive_cmd
		cmd_beat_t nxt;
		bit        free;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			mode <= MODE_START;
			center_x <= '0;
			center_y <= '0;
			radius <= '0;
			cmd_gap <= 0;
		end else begin
			free = !cmd_valid;
			if (cmd_valid && !cmd_stall) begin
				apply_cmd(on_bus);
				free = 1'b1;
			end
			if (free) begin
				if (cmd_gap != 0) begin
					cmd_gap <= cmd_gap - 1;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() != 0 &&
						(!cmd_backlog[0].hold || points_due.size() == 0)) begin
					nxt = cmd_backlog.pop_front();
					on_bus <= nxt;
					mode <= nxt.mode;
					center_x <= nxt.cx;
					center_y <= nxt.cy;
					radius <= nxt.rad;
					cmd_valid <= 1'b1;
					// Draw the gap after this beat; calm stretches have none.
					if (cmd_calm != 0) begin
						cmd_calm <= cmd_calm - 1;
						cmd_gap <= 0;
					end else begin
						cmd_gap <= $urandom_range(0, 9);
						if ($urandom_range(0, 24) == 0)
							cmd_calm <= $urandom_range(10, 40);
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted beat and stalls at random.
	always @(posedge clk or negedge arst_n) begin : check_res
		point_beat_t want;
		int          w;
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_wait <= 0;
		end else if (res_valid && !res_stall) begin
			if (points_due.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result: valid=%0b x=%0d y=%0d last=%0b",
						point_valid, point_x, point_y, last_point);
			end else begin
				want = points_due.pop_front();
				if (point_valid !== want.pv || point_x !== want.px ||
						point_y !== want.py || last_point !== want.last) begin
					fails++;
					if (fails <= 10)
						$display({"mismatch: expected valid=%0b x=%0d y=%0d last=%0b,",
							" got valid=%0b x=%0d y=%0d last=%0b"},
							want.pv, want.px, want.py, want.last,
							point_valid, point_x, point_y, last_point);
				end
			end
			if (res_calm != 0) begin
				res_calm <= res_calm - 1;
				w = 0;
			end else begin
				w = $urandom_range(0, 9);
				if ($urandom_range(0, 24) == 0)
					res_calm <= $urandom_range(10, 40);
			end
			res_wait <= w;
			res_stall <= (w != 0);
		end else if (res_valid && res_wait != 0) begin
			res_wait <= res_wait - 1;
			res_stall <= (res_wait > 1);
		end
	end

	task automatic queue_cmd(input logic m, input logic [CENTER_W-1:0] cx,
			input logic [CENTER_W-1:0] cy, input logic [RADIUS_W-1:0] r, input bit hold);
		cmd_beat_t c;
		c.mode = m;
		c.cx = cx;
		c.cy = cy;
		c.rad = r;
		c.hold = hold;
		cmd_backlog.push_back(c);
	endtask

	// Next beats carry random don't-care payload.
	task automatic queue_next(input int count);
		repeat (count)
			queue_cmd(MODE_NEXT, CENTER_W'($urandom), CENTER_W'($urandom),
				RADIUS_W'($urandom), 1'b0);
	endtask

	// Stimulus: a directed opening, then random circles of mostly small radius.
	initial begin : fill_backlog
		int r;
		int kind;
		int cnt;
		// Next before any start, then a zero radius circle.
		queue_next(1);
		queue_cmd(MODE_START, 12'h800, 12'h7ff, 9'd0, 1'b0);
		queue_next(1);
		// Radius one at the far corner: the whole circle and one beat past the end.
		queue_cmd(MODE_START, 12'h7ff, 12'h800, 9'd1, 1'b0);
		queue_next(5);
		// Largest radius, cut short by a new start that waits for the pipe to drain.
		queue_cmd(MODE_START, 12'h000, 12'h000, 9'd511, 1'b0);
		queue_next(3);
		queue_cmd(MODE_START, 12'hfff, 12'hfff, 9'd2, 1'b1);
		queue_next(2);

		while (cmd_backlog.size() < 400) begin
			kind = $urandom_range(0, 9);
			if (kind < 7)
				r = $urandom_range(0, 8);
			else if (kind < 9)
				r = $urandom_range(9, 30);
			else
				r = $urandom_range(0, 511);
			queue_cmd(MODE_START, CENTER_W'($urandom), CENTER_W'($urandom),
				RADIUS_W'(r), $urandom_range(0, 19) == 0);
			kind = $urandom_range(0, 9);
			if (r > 30)
				cnt = $urandom_range(0, 10);
			else if (kind < 6)
				cnt = 6 * r + $urandom_range(1, 3);
			else if (kind < 9)
				cnt = $urandom_range(0, 5 * r);
			else
				cnt = $urandom_range(0, 3);
			queue_next(cnt);
		end
	end

	// End of run: drain everything, settle, then report.
	initial begin : finish_run
		wait (arst_n);
		while (cmd_backlog.size() != 0 || cmd_valid || points_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule
